[rtl/vn_pkg.sv]
// shared types, widths and helpers for the 3d vector normalizer
`timescale 1ns / 1ps
package vn_pkg;

  localparam int unsigned MagW   = 32;
  localparam int unsigned ShW    = 5;
  localparam int unsigned LzW    = 6;
  localparam int unsigned SqW    = 64;
  localparam int unsigned RootW  = 32;
  localparam int unsigned RemW   = 35;
  localparam int unsigned QW     = 17;
  localparam int unsigned FracW  = 16;
  localparam int unsigned NumW   = MagW + FracW + 1;
  localparam int unsigned OutW   = 18;
  localparam int unsigned Lanes  = 3;
  localparam logic [QW-1:0] OneQ16 = QW'(65536);

  typedef struct packed {
    logic [Lanes-1:0][MagW-1:0] mag;
    logic [Lanes-1:0]           neg;
    logic                       zero;
  } vn_side_t;

  function automatic logic [LzW-1:0] lzc32(input logic [MagW-1:0] v);
    logic [LzW-1:0] n;
    logic           found;
    n     = LzW'(MagW);
    found = 1'b0;
    for (int i = MagW - 1; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = LzW'(MagW - 1 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

[rtl/vn_in_if.sv]
// input channel carrying one vector per beat
`timescale 1ns / 1ps
interface vn_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  modport source (output valid, vec_x, vec_y, vec_z, input ready);
  modport sink (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

[rtl/vn_out_if.sv]
// output channel carrying one unit vector per beat
`timescale 1ns / 1ps
interface vn_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] unit_x;
  logic signed [17:0] unit_y;
  logic signed [17:0] unit_z;
  logic               was_zero;
  modport source (output valid, unit_x, unit_y, unit_z, was_zero, input ready);
  modport sink (input valid, unit_x, unit_y, unit_z, was_zero, output ready);
endinterface

[rtl/vn_prep.sv]
// magnitude, common normalizing shift, squares and sum of squares
`timescale 1ns / 1ps
module vn_prep import vn_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [Lanes-1:0][MagW-1:0] vec_i,
  output logic                       valid_o,
  output logic [SqW-1:0]             sum_o,
  output vn_side_t                   side_o
);

  logic [3:0] v_q;
  vn_side_t   a_d, a_q, b_d, b_q, c_q, d_q;
  logic [ShW-1:0] sh_d, sh_q;
  logic [LzW-1:0] lz;
  logic [Lanes-1:0][SqW-1:0] sq_d, sq_q;
  logic [SqW-1:0] sum_d, sum_q;
  logic [MagW-1:0] any;

  always_comb begin
    any = '0;
    for (int i = 0; i < Lanes; i++) begin
      a_d.neg[i] = vec_i[i][MagW-1];
      a_d.mag[i] = vec_i[i][MagW-1] ? MagW'(0) - vec_i[i] : vec_i[i];
      any        = any | a_d.mag[i];
    end
    a_d.zero = (any == '0);
    lz       = lzc32(any);
    sh_d     = (lz == '0) ? '0 : ShW'(lz - LzW'(1));
  end

  always_comb begin
    b_d = a_q;
    for (int i = 0; i < Lanes; i++) begin
      b_d.mag[i] = a_q.mag[i] << sh_q;
    end
  end

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      sq_d[i] = b_q.mag[i] * b_q.mag[i];
    end
    sum_d = sq_q[0] + sq_q[1] + sq_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q   <= a_d;
      sh_q  <= sh_d;
      b_q   <= b_d;
      sq_q  <= sq_d;
      c_q   <= b_q;
      sum_q <= sum_d;
      d_q   <= c_q;
    end
  end

  assign valid_o = v_q[3];
  assign sum_o   = sum_q;
  assign side_o  = d_q;

endmodule

[rtl/vn_sqrt.sv]
// pipelined floor square root, one root bit per stage
`timescale 1ns / 1ps
module vn_sqrt import vn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [SqW-1:0]   sum_i,
  input  vn_side_t         side_i,
  output logic             valid_o,
  output logic [RootW-1:0] root_o,
  output vn_side_t         side_o
);

  logic [RootW-1:0]  v_q;
  logic [RemW-1:0]   r_q [RootW];
  logic [RootW-1:0]  y_q [RootW];
  logic [SqW-1:0]    n_q [RootW];
  vn_side_t          s_q [RootW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[RootW-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic [RemW-1:0]  r_p, rin, trial, r_d;
    logic [RootW-1:0] y_p, y_d;
    logic [SqW-1:0]   n_p;
    vn_side_t         s_p;

    if (k == 0) begin : g_first
      assign r_p = '0;
      assign y_p = '0;
      assign n_p = sum_i;
      assign s_p = side_i;
    end else begin : g_next
      assign r_p = r_q[k-1];
      assign y_p = y_q[k-1];
      assign n_p = n_q[k-1];
      assign s_p = s_q[k-1];
    end

    always_comb begin
      rin   = {r_p[RemW-3:0], n_p[SqW-1:SqW-2]};
      trial = RemW'({y_p, 2'b01});
      if (rin >= trial) begin
        r_d = rin - trial;
        y_d = {y_p[RootW-2:0], 1'b1};
      end else begin
        r_d = rin;
        y_d = {y_p[RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k] <= r_d;
        y_q[k] <= y_d;
        n_q[k] <= {n_p[SqW-3:0], 2'b00};
        s_q[k] <= s_p;
      end
    end
  end

  assign valid_o = v_q[RootW-1];
  assign root_o  = y_q[RootW-1];
  assign side_o  = s_q[RootW-1];

endmodule

[rtl/vn_div.sv]
// one divider lane: rounded quotient of a component by the length, sign restored
`timescale 1ns / 1ps
module vn_div import vn_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [MagW-1:0]        mag_i,
  input  logic [RootW-1:0]       len_i,
  input  logic                   neg_i,
  input  logic                   zero_i,
  output logic                   valid_o,
  output logic signed [OutW-1:0] unit_o,
  output logic                   zero_o
);

  logic [QW+1:0]    v_q;
  logic [NumW-1:0]  num_q;
  logic [RootW-1:0] len_q;
  logic             neg_q, zero_q;

  logic [MagW-1:0]  r_q  [QW];
  logic [QW-1:0]    q_q  [QW];
  logic [QW-1:0]    n_q  [QW];
  logic [RootW-1:0] l_q  [QW];
  logic             ng_q [QW];
  logic             z_q  [QW];

  logic [QW-1:0]           qc;
  logic signed [OutW-1:0]  unit_d, unit_q;
  logic                    zo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QW:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= {1'b0, mag_i, {FracW{1'b0}}} + NumW'(len_i >> 1);
      len_q  <= len_i;
      neg_q  <= neg_i;
      zero_q <= zero_i;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [MagW-1:0]  r_p, r_d;
    logic [QW-1:0]    q_p, q_d, n_p;
    logic [RootW-1:0] l_p;
    logic             ng_p, z_p;
    logic [MagW:0]    rin;

    if (k == 0) begin : g_first
      assign r_p  = num_q[NumW-1:QW];
      assign q_p  = '0;
      assign n_p  = num_q[QW-1:0];
      assign l_p  = len_q;
      assign ng_p = neg_q;
      assign z_p  = zero_q;
    end else begin : g_next
      assign r_p  = r_q[k-1];
      assign q_p  = q_q[k-1];
      assign n_p  = n_q[k-1];
      assign l_p  = l_q[k-1];
      assign ng_p = ng_q[k-1];
      assign z_p  = z_q[k-1];
    end

    always_comb begin
      rin = {r_p, n_p[QW-1]};
      if (rin >= {1'b0, l_p}) begin
        r_d = MagW'(rin - {1'b0, l_p});
        q_d = {q_p[QW-2:0], 1'b1};
      end else begin
        r_d = rin[MagW-1:0];
        q_d = {q_p[QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]  <= r_d;
        q_q[k]  <= q_d;
        n_q[k]  <= {n_p[QW-2:0], 1'b0};
        l_q[k]  <= l_p;
        ng_q[k] <= ng_p;
        z_q[k]  <= z_p;
      end
    end
  end

  always_comb begin
    qc     = (q_q[QW-1] > OneQ16) ? OneQ16 : q_q[QW-1];
    unit_d = ng_q[QW-1] ? OutW'(-$signed({1'b0, qc})) : $signed({1'b0, qc});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      unit_q <= unit_d;
      zo_q   <= z_q[QW-1];
    end
  end

  assign valid_o = v_q[QW+1];
  assign unit_o  = unit_q;
  assign zero_o  = zo_q;

endmodule

[rtl/vector_normalize_3d.sv]
// top level: prep, square root, three divider lanes and the merging output register
// throughput: one vector per cycle; every stage advances together when the
// output register is empty or being taken, so a stall on out_o holds the pipe
// reset: rst_ni clears all valid bits; no state is kept between vectors
`timescale 1ns / 1ps
module vector_normalize_3d import vn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  vn_in_if.sink    in_i,
  vn_out_if.source out_o
);

  logic                       en;
  logic [Lanes-1:0][MagW-1:0] vec;
  logic                       p_v, s_v;
  logic [SqW-1:0]             p_sum;
  vn_side_t                   p_side, s_side;
  logic [RootW-1:0]           root;
  logic [Lanes-1:0]           l_v, l_z;
  logic signed [OutW-1:0]     l_u [Lanes];

  logic                   out_v_q, zero_q;
  logic signed [OutW-1:0] ux_q, uy_q, uz_q;

  assign en      = !out_v_q || out_o.ready;
  assign in_i.ready = en;
  assign vec[0]  = in_i.vec_x;
  assign vec[1]  = in_i.vec_y;
  assign vec[2]  = in_i.vec_z;

  vn_prep u_prep (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_i.valid), .vec_i(vec),
    .valid_o(p_v), .sum_o(p_sum), .side_o(p_side)
  );

  vn_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(p_v), .sum_i(p_sum), .side_i(p_side),
    .valid_o(s_v), .root_o(root), .side_o(s_side)
  );

  for (genvar i = 0; i < Lanes; i++) begin : g_lane
    vn_div u_div (
      .clk_i, .rst_ni, .en_i(en), .valid_i(s_v), .mag_i(s_side.mag[i]),
      .len_i(root), .neg_i(s_side.neg[i]), .zero_i(s_side.zero),
      .valid_o(l_v[i]), .unit_o(l_u[i]), .zero_o(l_z[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= l_v[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      zero_q <= &l_z;
      ux_q   <= (&l_z) ? '0 : l_u[0];
      uy_q   <= (&l_z) ? '0 : l_u[1];
      uz_q   <= (&l_z) ? '0 : l_u[2];
    end
  end

  assign out_o.valid    = out_v_q;
  assign out_o.unit_x   = ux_q;
  assign out_o.unit_y   = uy_q;
  assign out_o.unit_z   = uz_q;
  assign out_o.was_zero = zero_q;

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (l_v[0] == l_v[1]) && (l_v[1] == l_v[2]))
    else $error("divider lanes out of step");

  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && zero_q |-> ux_q == '0 && uy_q == '0 && uz_q == '0)
    else $error("zero vector gave nonzero output");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> ux_q <= OutW'(65536) && ux_q >= -OutW'(65536)
             && uy_q <= OutW'(65536) && uy_q >= -OutW'(65536)
             && uz_q <= OutW'(65536) && uz_q >= -OutW'(65536))
    else $error("unit component out of range");

endmodule
